>>> rtl/core/smd_pkg.sv
// smd_pkg: shared constants, request and status codes, and the
// controller-to-datapath command and status structs of the stack block.
// No dependencies.
`default_nettype none

package smd_pkg;

    // storage geometry
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // request codes
    localparam logic [1:0] REQ_PUSH = 2'd0;
    localparam logic [1:0] REQ_POP  = 2'd1;
    localparam logic [1:0] REQ_DMID = 2'd2;

    // status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic       load_req;
        logic       do_push;
        logic       dec_count;
        logic       status_load;
        logic [1:0] status_code;
        logic       idx_load;
        logic       shift_rd;
        logic       shift_wr;
        logic       rd_result;
        logic       load_out;
    } smd_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] req;
        logic       full;
        logic       empty;
        logic       shift_more;
        logic       out_free;
    } smd_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/smd_datapath.sv
// smd_datapath: entry memory, fill count, shift index, read registers
// and the result register of the stack block.
// Depends on smd_pkg.
`default_nettype none

module smd_datapath
    import smd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic [1:0]               req_type,
    input  wire logic signed [DATA_W-1:0] push_value,
    input  wire smd_cmd_t                 cmd,
    output smd_stat_t                     stat,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      top_value,
    output logic signed [DATA_W-1:0]      middle_value,
    output logic [CNT_W-1:0]              fill_count,
    output logic                          is_empty,
    output logic [1:0]                    status
);

    // entry memory, bottom at address 0
    logic [DATA_W-1:0] mem [DEPTH];

    logic [1:0]        req_reg;
    logic [DATA_W-1:0] val_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [1:0]        stat_reg;
    logic [DATA_W-1:0] rd_top_reg;
    logic [DATA_W-1:0] rd_mid_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] top_out_reg;
    logic [DATA_W-1:0] mid_out_reg;
    logic [CNT_W-1:0]  cnt_out_reg;
    logic [1:0]        stat_out_reg;

    logic [CNT_W-1:0]  last_pos;
    logic [ADDR_W-1:0] top_addr;
    logic [ADDR_W-1:0] mid_addr;
    logic [CNT_W-1:0]  idx_plus;
    logic [ADDR_W-1:0] rd_addr_a;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              cnt_zero;

    // address arithmetic
    assign cnt_zero  = (count_reg == '0);
    assign last_pos  = count_reg - CNT_W'(1);
    assign top_addr  = last_pos[ADDR_W-1:0];
    assign mid_addr  = last_pos[ADDR_W:1];
    assign idx_plus  = {{(CNT_W-ADDR_W){1'b0}}, idx_reg} + CNT_W'(1);
    assign rd_addr_a = cmd.shift_rd ? idx_plus[ADDR_W-1:0] : top_addr;

    // single write port: push at the top, or shift one entry down
    assign wr_en   = cmd.do_push | cmd.shift_wr;
    assign wr_addr = cmd.do_push ? count_reg[ADDR_W-1:0] : idx_reg;
    assign wr_data = cmd.do_push ? val_reg : rd_top_reg;

    // memory write and registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.shift_rd || cmd.rd_result)
        begin
            rd_top_reg <= mem[rd_addr_a];
            rd_mid_reg <= mem[mid_addr];
        end
    end

    // request latch, status code, result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_type;
            val_reg <= push_value;
        end
        if (cmd.status_load)
        begin
            stat_reg <= cmd.status_code;
        end
        if (cmd.load_out)
        begin
            top_out_reg  <= cnt_zero ? '0 : rd_top_reg;
            mid_out_reg  <= cnt_zero ? '0 : rd_mid_reg;
            cnt_out_reg  <= count_reg;
            stat_out_reg <= stat_reg;
        end
    end

    // fill count and shift index
    always_comb
    begin
        count_next = count_reg;
        if (cmd.do_push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.dec_count)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.idx_load)
        begin
            idx_next = mid_addr;
        end
        else if (cmd.shift_wr)
        begin
            idx_next = idx_plus[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // status toward the controller
    assign stat.req        = req_reg;
    assign stat.full       = (count_reg == CNT_W'(DEPTH));
    assign stat.empty      = cnt_zero;
    assign stat.shift_more = (idx_plus < count_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // result ports
    assign out_valid    = out_valid_reg;
    assign top_value    = top_out_reg;
    assign middle_value = mid_out_reg;
    assign fill_count   = cnt_out_reg;
    assign is_empty     = (cnt_out_reg == '0);
    assign status       = stat_out_reg;

    // count stays within the storage
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // a push only happens with room and grows the count by one
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_push |-> !stat.full ##1 count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the count");

    // a result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result overwritten");

endmodule

`default_nettype wire

>>> rtl/core/smd_ctrl.sv
// smd_ctrl: state machine that sequences push, pop and delete-middle
// over the datapath, one item at a time.
// Depends on smd_pkg.
`default_nettype none

module smd_ctrl
    import smd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire smd_stat_t stat,
    output smd_cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_SH_RD = 3'd2;
    localparam logic [2:0] S_SH_WR = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.status_load = 1'b1;
                cmd.status_code = STAT_OK;
                state_next      = S_RD;
                unique case (stat.req)
                    REQ_PUSH:
                    begin
                        if (stat.full)
                        begin
                            cmd.status_code = STAT_FULL;
                        end
                        else
                        begin
                            cmd.do_push = 1'b1;
                        end
                    end
                    REQ_POP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_code = STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.dec_count = 1'b1;
                        end
                    end
                    REQ_DMID:
                    begin
                        if (stat.empty)
                        begin
                            cmd.status_code = STAT_EMPTY;
                        end
                        else
                        begin
                            cmd.idx_load = 1'b1;
                            state_next   = S_SH_RD;
                        end
                    end
                    default:
                    begin
                        cmd.status_code = STAT_OK;
                    end
                endcase
            end
            S_SH_RD:
            begin
                // fetch the entry above the gap, or finish the shift
                if (stat.shift_more)
                begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SH_WR;
                end
                else
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_RD;
                end
            end
            S_SH_WR:
            begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SH_RD;
            end
            S_RD:
            begin
                cmd.rd_result = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // an accepted item always goes to execution
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == S_EXEC)
        else $error("accepted item not executed");

    // every shift write follows its read
    a_shift_pair: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift_wr |-> $past(cmd.shift_rd))
        else $error("shift write without read");

    // the result is loaded right after the read when the output is free
    a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && stat.out_free) |=> state_reg == S_IDLE)
        else $error("finished item not delivered");

endmodule

`default_nettype wire

>>> rtl/core/stack_with_middle_delete_unit.sv
// stack_with_middle_delete_unit: top level of the bounded stack with
// delete-middle. Depends on smd_pkg, smd_ctrl and smd_datapath.
//
// Usage:
//   Input channel in_valid/in_ready carries one item: req_type (push, pop,
//   delete middle) and push_value. Output channel out_valid/out_ready
//   carries one result per item: top_value, middle_value, fill_count,
//   is_empty and status.
//   Push, pop, the unused code and errors go through execution, result read
//   and result load; delete-middle also moves k = count - 1 - (count-1)/2
//   entries down between execution and result read, with one read and
//   one write per entry on the single write port of the entry memory.
//   One item at a time: the next item can be taken in the cycle after the
//   previous result is loaded into the output register.
//   Reset clears the fill count, the control state and out_valid; the
//   stack starts empty.
//   When the receiver stalls, the result stays in the output register and
//   the next item is still accepted and processed; it waits before its
//   result load until the output register has been emptied.
`default_nettype none

module stack_with_middle_delete_unit
    import smd_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [1:0]               req_type,
    input  wire logic signed [DATA_W-1:0] push_value,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      top_value,
    output logic signed [DATA_W-1:0]      middle_value,
    output logic [CNT_W-1:0]              fill_count,
    output logic                          is_empty,
    output logic [1:0]                    status
);

    smd_cmd_t  cmd;
    smd_stat_t stat;

    // sequencer
    smd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and result register
    smd_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_type     (req_type),
        .push_value   (push_value),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .top_value    (top_value),
        .middle_value (middle_value),
        .fill_count   (fill_count),
        .is_empty     (is_empty),
        .status       (status)
    );

endmodule

`default_nettype wire

>>> tb/stack_with_middle_delete_unit_tb.sv
// stack_with_middle_delete_unit_tb: self-checking testbench for the stack with delete-middle;
// drives push, pop, delete-middle and unused-code items with random idling and checks every result.
// Depends on smd_pkg and stack_with_middle_delete_unit.
`timescale 1ns / 1ps

module stack_with_middle_delete_unit_tb
    import smd_pkg::*;
();

    // request code 3 is unused by the block and must act as a no-op
    localparam logic [1:0] REQ_NONE = 2'd3;
    localparam int MAX_GAP = 12;
    localparam int RANDOM_OPS = 1920;
    localparam int LONG_HOLD = 250;
    localparam int MAX_REPORTS = 10;

    // one request as offered to the block
    typedef struct {
        logic [1:0]               req;
        logic signed [DATA_W-1:0] value;
        int                       gap;
        bit                       drain;
    } stack_op_t;

    // one result as reported after a request
    typedef struct {
        logic signed [DATA_W-1:0] top;
        logic signed [DATA_W-1:0] middle;
        logic [CNT_W-1:0]         count;
        logic                     empty;
        logic [1:0]               status;
    } stack_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               req_type = REQ_PUSH;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] middle_value;
    logic [CNT_W-1:0]         fill_count;
    logic                     is_empty;
    logic [1:0]               status;

    stack_op_t                pending_ops[$];
    stack_result_t            expected_results[$];
    logic signed [DATA_W-1:0] stk_mem [0:DEPTH-1];
    int                       stk_count = 0;
    int                       error_count = 0;
    int                       results_seen = 0;
    int                       tx_wait = 0;
    int                       rx_wait = 0;
    bit                       tx_quiet = 1'b0;
    bit                       rx_quiet = 1'b0;
    logic                     in_fire = 1'b0;
    logic                     out_fire = 1'b0;

    stack_with_middle_delete_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .top_value    (top_value),
        .middle_value (middle_value),
        .fill_count   (fill_count),
        .is_empty     (is_empty),
        .status       (status)
    );

    // clock, 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // stack predictor: applies one request and returns what the block should report
    function automatic stack_result_t apply_stack_op(logic [1:0] op,
                                                     logic signed [DATA_W-1:0] val);
        stack_result_t r;
        int            mid;
        r.status = STAT_OK;
        case (op)
            REQ_PUSH:
            begin
                if (stk_count >= DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    stk_mem[stk_count] = val;
                    stk_count++;
                end
            end
            REQ_POP:
            begin
                if (stk_count == 0)
                    r.status = STAT_EMPTY;
                else
                    stk_count--;
            end
            REQ_DMID:
            begin
                if (stk_count == 0)
                    r.status = STAT_EMPTY;
                else
                begin
                    // lower middle leaves, entries above slide down one place
                    mid = (stk_count - 1) / 2;
                    for (int i = mid; i < stk_count - 1; i++)
                        stk_mem[i] = stk_mem[i + 1];
                    stk_count--;
                end
            end
            default: ;
        endcase
        if (stk_count > 0)
        begin
            r.top    = stk_mem[stk_count - 1];
            r.middle = stk_mem[(stk_count - 1) / 2];
        end
        else
        begin
            r.top    = '0;
            r.middle = '0;
        end
        r.count = CNT_W'(stk_count);
        r.empty = (stk_count == 0);
        return r;
    endfunction

    // append one request with its idle gap to the send queue
    function automatic void queue_op(logic [1:0] op, logic signed [DATA_W-1:0] val, bit drain);
        stack_op_t s;
        s.req   = op;
        s.value = val;
        s.gap   = tx_quiet ? 0 : $urandom_range(0, MAX_GAP);
        s.drain = drain;
        pending_ops.push_back(s);
    endfunction

    // sampling at the rising edge: handshake flags, prediction and checking
    always @(posedge clk)
    begin
        stack_result_t exp_r;
        in_fire  <= rst_n && in_valid && in_ready;
        out_fire <= rst_n && out_valid && out_ready;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with no item pending: top %h mid %h cnt %0d st %0d",
                             $realtime, top_value, middle_value, fill_count, status);
            end
            else
            begin
                exp_r = expected_results.pop_front();
                if (top_value !== exp_r.top || middle_value !== exp_r.middle ||
                    fill_count !== exp_r.count || is_empty !== exp_r.empty ||
                    status !== exp_r.status)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                    begin
                        $display("%0t: exp top %h mid %h cnt %0d empty %0d st %0d",
                                 $realtime, exp_r.top, exp_r.middle, exp_r.count,
                                 exp_r.empty, exp_r.status);
                        $display("    got top %h mid %h cnt %0d empty %0d st %0d",
                                 top_value, middle_value, fill_count, is_empty, status);
                    end
                end
            end
        end
        if (rst_n && in_valid && in_ready)
            expected_results.push_back(apply_stack_op(req_type, push_value));
    end

    // item driver: gap before each item, drain items wait for all results
    always @(negedge clk)
    begin
        stack_op_t op;
        logic      next_valid;
        next_valid = in_valid;
        if (in_valid && in_fire)
        begin
            next_valid = 1'b0;
            tx_wait = (pending_ops.size() != 0) ? pending_ops[0].gap : 0;
        end
        if (rst_n && !next_valid)
        begin
            if (tx_wait > 0)
                tx_wait--;
            else if (pending_ops.size() != 0 &&
                     !(pending_ops[0].drain && expected_results.size() != 0))
            begin
                op = pending_ops.pop_front();
                next_valid = 1'b1;
                req_type   <= op.req;
                push_value <= op.value;
            end
        end
        in_valid <= next_valid;
    end

    // result receiver: random stall per result, with a few long hold-offs
    always @(negedge clk)
    begin
        if (out_fire)
        begin
            results_seen++;
            if (results_seen % 700 == 150)
                rx_wait = LONG_HOLD;
            else
                rx_wait = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
            if (results_seen % 97 == 0)
                rx_quiet = !rx_quiet;
        end
        if (!rst_n)
            out_ready <= 1'b0;
        else if (rx_wait > 0)
        begin
            rx_wait--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // stimulus, reset and end of run
    initial
    begin
        int push_pct;
        int roll;
        logic [1:0] op;

        // directed: removals and no-op on empty, extreme values, delete-middle
        queue_op(REQ_POP, 32'sd0, 1'b0);
        queue_op(REQ_DMID, 32'sd0, 1'b0);
        queue_op(REQ_NONE, $urandom, 1'b0);
        queue_op(REQ_PUSH, 32'sh7fffffff, 1'b0);
        queue_op(REQ_PUSH, 32'sh80000000, 1'b0);
        queue_op(REQ_DMID, $urandom, 1'b0);
        queue_op(REQ_PUSH, 32'sd0, 1'b0);
        queue_op(REQ_PUSH, -32'sd1, 1'b0);
        queue_op(REQ_PUSH, 32'sh55555555, 1'b0);
        queue_op(REQ_DMID, 32'sd0, 1'b0);
        queue_op(REQ_NONE, 32'sd0, 1'b0);
        queue_op(REQ_POP, $urandom, 1'b0);
        queue_op(REQ_POP, 32'sd0, 1'b0);
        queue_op(REQ_POP, 32'sd0, 1'b0);
        // fill to the top, then push and delete-middle on full, then a no-op
        for (int i = 0; i < DEPTH; i++)
            queue_op(REQ_PUSH, $urandom, i == 0);
        queue_op(REQ_PUSH, 32'shaaaaaaaa, 1'b0);
        queue_op(REQ_DMID, 32'sd0, 1'b0);
        queue_op(REQ_NONE, 32'sd0, 1'b0);

        // random: runs of push-heavy, balanced and removal-heavy traffic
        push_pct = 50;
        for (int i = 0; i < RANDOM_OPS; i++)
        begin
            if (i % 40 == 0)
                case ($urandom_range(0, 2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
            if (i % 53 == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            roll = $urandom_range(0, 99);
            if (roll < 5)
                op = REQ_NONE;
            else if (roll < 5 + push_pct * 95 / 100)
                op = REQ_PUSH;
            else
                op = $urandom_range(0, 1) ? REQ_POP : REQ_DMID;
            queue_op(op, $urandom, i % 480 == 479);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_ops.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
